/* hdl/mcds_pkg.sv */
// Package for the multi-channel duty cycle scheduler.
// Holds command codes, FSM states, the channel record type and the tick update.
// No dependencies.
package mcds_pkg;

  localparam int CHANNELS_DEF       = 15;
  localparam int PERIOD_ENTRIES_DEF = 80;

  localparam int CMD_W    = 2;
  localparam int CHAN_W   = 4;
  localparam int PERIOD_W = 7;
  localparam int COUNT_W  = 6;
  localparam int MASK_W   = 15;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_SETUP = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_RMW,
    ST_FINISH
  } state_e;

  // One channel record as kept in the channel store
  typedef struct packed {
    logic                enable;
    logic [PERIOD_W-1:0] period;
    logic [COUNT_W-1:0]  counter;
  } rec_t;

  typedef struct packed {
    rec_t rec;
    logic level;
    logic fire;
  } upd_t;

  // Advance one channel by one tick
  function automatic upd_t tick_update(rec_t rec, logic level);
    upd_t                u;
    logic [PERIOD_W-1:0] hi_len;
    logic [PERIOD_W-1:0] lo_len;
    logic [PERIOD_W-1:0] len;
    logic [COUNT_W-1:0]  cnt;
    logic                elapsed;
    u.rec   = rec;
    u.level = level;
    u.fire  = 1'b0;
    hi_len  = PERIOD_W'(({1'b0, rec.period} + {{PERIOD_W{1'b0}}, 1'b1}) >> 1);
    lo_len  = (rec.period == '0) ? '0
            : ({1'b0, rec.period[PERIOD_W-1:1]} + {{(PERIOD_W-1){1'b0}}, 1'b1});
    len     = level ? hi_len : lo_len;
    cnt     = rec.counter;
    elapsed = (len <= {1'b0, cnt}) || (cnt == COUNT_MAX);
    if (rec.enable && (hi_len != '0) && (lo_len != '0)) begin
      if (elapsed) begin
        cnt     = '0;
        u.level = ~level;
        u.fire  = ~level;
      end
      if (cnt != COUNT_MAX) begin
        cnt = cnt + {{(COUNT_W-1){1'b0}}, 1'b1};
      end
      u.rec.counter = cnt;
    end
    return u;
  endfunction

endpackage

/* hdl/mcds_if.sv */
// Valid/ready channel interfaces for command items and result items.
// Depends on mcds_pkg for field widths.
interface mcds_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [mcds_pkg::CMD_W-1:0]    cmd;
  logic [mcds_pkg::CHAN_W-1:0]   channel;
  logic                          enable;
  logic [mcds_pkg::PERIOD_W-1:0] period_select;

  modport source (output valid, cmd, channel, enable, period_select, input ready);
  modport sink   (input valid, cmd, channel, enable, period_select, output ready);
endinterface

interface mcds_res_if;
  logic                        valid;
  logic                        ready;
  logic [mcds_pkg::MASK_W-1:0] fire_mask;
  logic [mcds_pkg::MASK_W-1:0] level_mask;

  modport source (output valid, fire_mask, level_mask, input ready);
  modport sink   (input valid, fire_mask, level_mask, output ready);
endinterface

/* hdl/mcds_store.sv */
// Channel record store: synchronous memory with a registered read port.
// Per-entry valid bits make unwritten entries read as all zero. Uses mcds_pkg.
module mcds_store #(
  parameter int CHANNELS = mcds_pkg::CHANNELS_DEF,
  parameter int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [ADDR_W-1:0]    rd_addr_i,
  output mcds_pkg::rec_t       rd_data_o,
  input  logic                 wr_en_i,
  input  logic [ADDR_W-1:0]    wr_addr_i,
  input  mcds_pkg::rec_t       wr_data_i
);

  mcds_pkg::rec_t        mem [CHANNELS];
  logic [CHANNELS-1:0]   valid_q;
  logic                  rd_valid_q;
  mcds_pkg::rec_t        rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // Track written entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

/* hdl/multi_channel_duty_cycle_scheduler_top.sv */
// Multi-channel duty cycle scheduler: one result item per command item.
// Tick: every channel record is read, updated and written back in turn, then the result is registered.
// Setup or clear of a valid channel: the record is read, then written back, then the result is registered.
// Unused codes and out-of-range channels: the result is registered with no store access.
// A result still waiting holds the next item in its last cycle until the output frees up.
// Reset clears all levels and marks every channel record as zero.
module multi_channel_duty_cycle_scheduler_top #(
  parameter int CHANNELS       = mcds_pkg::CHANNELS_DEF,
  parameter int PERIOD_ENTRIES = mcds_pkg::PERIOD_ENTRIES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mcds_cmd_if.sink   item_i,
  mcds_res_if.source result_o
);

  localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EXT_W  = mcds_pkg::CHAN_W + 2;

  mcds_pkg::state_e              state_q, state_d;
  logic [mcds_pkg::CMD_W-1:0]    cmd_q;
  logic [EXT_W-1:0]              chan_q;
  logic                          enable_q;
  logic [mcds_pkg::PERIOD_W-1:0] sel_q;
  logic [ADDR_W-1:0]             idx_q, idx_d;
  logic [CHANNELS-1:0]           fire_q;
  logic [CHANNELS-1:0]           level_q;
  logic                          out_valid_q;
  logic [mcds_pkg::MASK_W-1:0]   out_fire_q;
  logic [mcds_pkg::MASK_W-1:0]   out_level_q;

  logic                          accept;
  logic                          slot_free;
  logic [EXT_W-1:0]              in_chan_ext;
  logic                          in_chan_ok;
  logic [mcds_pkg::PERIOD_W-1:0] in_sel_clamp;
  logic                          last_idx;

  logic                          rd_en;
  logic [ADDR_W-1:0]             rd_addr;
  mcds_pkg::rec_t                rd_data;
  logic                          wr_en;
  logic [ADDR_W-1:0]             wr_addr;
  mcds_pkg::rec_t                wr_data;
  mcds_pkg::upd_t                upd;

  logic [mcds_pkg::MASK_W+CHANNELS-1:0] fire_ext;
  logic [mcds_pkg::MASK_W+CHANNELS-1:0] level_ext;

  mcds_store #(
    .CHANNELS (CHANNELS),
    .ADDR_W   (ADDR_W)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // Input decode
  assign item_i.ready = (state_q == mcds_pkg::ST_IDLE);
  assign accept       = item_i.valid && item_i.ready;
  assign slot_free    = !out_valid_q || result_o.ready;
  assign in_chan_ext  = {2'b00, item_i.channel};
  assign in_chan_ok   = (in_chan_ext < EXT_W'(CHANNELS));
  assign in_sel_clamp =
      ({1'b0, item_i.period_select} >= (mcds_pkg::PERIOD_W + 1)'(PERIOD_ENTRIES))
      ? mcds_pkg::PERIOD_W'(PERIOD_ENTRIES - 1) : item_i.period_select;
  assign last_idx     = (idx_q == ADDR_W'(CHANNELS - 1));

  // Tick update of the record being swept
  assign upd = mcds_pkg::tick_update(rd_data, level_q[idx_q]);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mcds_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (mcds_pkg::cmd_e'(item_i.cmd)) inside
            mcds_pkg::CMD_TICK: state_d = mcds_pkg::ST_SWEEP;
            mcds_pkg::CMD_SETUP,
            mcds_pkg::CMD_CLEAR: state_d = in_chan_ok ? mcds_pkg::ST_RMW
                                                      : mcds_pkg::ST_FINISH;
            default: state_d = mcds_pkg::ST_FINISH;
          endcase
        end
      end
      mcds_pkg::ST_SWEEP: begin
        if (last_idx) begin
          state_d = mcds_pkg::ST_FINISH;
        end
      end
      mcds_pkg::ST_RMW: state_d = mcds_pkg::ST_FINISH;
      mcds_pkg::ST_FINISH: begin
        if (slot_free) begin
          state_d = mcds_pkg::ST_IDLE;
        end
      end
      default: state_d = mcds_pkg::ST_IDLE;
    endcase
  end

  // Store access and sweep index
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_q;
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = upd.rec;
    idx_d   = idx_q;
    unique case (state_q)
      mcds_pkg::ST_IDLE: begin
        if (accept) begin
          if (mcds_pkg::cmd_e'(item_i.cmd) == mcds_pkg::CMD_TICK) begin
            rd_en   = 1'b1;
            rd_addr = '0;
            idx_d   = '0;
          end else if (in_chan_ok) begin
            rd_en   = 1'b1;
            rd_addr = in_chan_ext[ADDR_W-1:0];
          end
        end
      end
      mcds_pkg::ST_SWEEP: begin
        wr_en = 1'b1;
        if (!last_idx) begin
          rd_en   = 1'b1;
          rd_addr = idx_q + ADDR_W'(1);
          idx_d   = idx_q + ADDR_W'(1);
        end
      end
      mcds_pkg::ST_RMW: begin
        wr_en   = 1'b1;
        wr_addr = chan_q[ADDR_W-1:0];
        wr_data = rd_data;
        if (mcds_pkg::cmd_e'(cmd_q) == mcds_pkg::CMD_SETUP) begin
          wr_data.enable = enable_q;
          wr_data.period = sel_q;
        end else begin
          wr_data.counter = '0;
        end
      end
      mcds_pkg::ST_FINISH: ;
      default: ;
    endcase
  end

  // Hold the accepted item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= item_i.cmd;
      chan_q   <= in_chan_ext;
      enable_q <= item_i.enable;
      sel_q    <= in_sel_clamp;
    end
  end

  // Size channel vectors to the result mask width
  assign fire_ext  = {{mcds_pkg::MASK_W{1'b0}}, fire_q};
  assign level_ext = {{mcds_pkg::MASK_W{1'b0}}, level_q};

  // Control, levels, fire accumulation and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mcds_pkg::ST_IDLE;
      idx_q       <= '0;
      fire_q      <= '0;
      level_q     <= '0;
      out_valid_q <= 1'b0;
      out_fire_q  <= '0;
      out_level_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (accept) begin
        fire_q <= '0;
      end
      if (state_q == mcds_pkg::ST_SWEEP) begin
        level_q[idx_q] <= upd.level;
        fire_q[idx_q]  <= upd.fire;
      end
      if ((state_q == mcds_pkg::ST_FINISH) && slot_free) begin
        out_valid_q <= 1'b1;
        out_fire_q  <= fire_ext[mcds_pkg::MASK_W-1:0];
        out_level_q <= level_ext[mcds_pkg::MASK_W-1:0];
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.fire_mask  = out_fire_q;
  assign result_o.level_mask = out_level_q;

endmodule
